// ===== sv/mcurb_pkg.sv =====
// Package: shared types and constants for the multi-channel serial ring buffers.
package mcurb_pkg;

	localparam int DEF_CHANNELS   = 8;
	localparam int DEF_RING_DEPTH = 256;

	localparam logic [7:0] EMPTY_RX_BYTE = 8'hEE;

	typedef enum logic [1:0] {
		MODE_TX_PUSH = 2'd0,
		MODE_TX_POP  = 2'd1,
		MODE_RX_PUSH = 2'd2,
		MODE_RX_POP  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] channel;
		logic [7:0] data_in;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       data_valid;
		logic [8:0] rx_fill;
		logic       tx_empty;
		logic       overflow;
	} rsp_item_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} ring_req_t;

	typedef struct packed {
		logic       data_valid;
		logic       rd_rx;
		logic       rx_empty_pop;
		logic [8:0] rx_fill;
		logic       tx_empty;
		logic       overflow;
	} ring_status_t;

endpackage

// ===== sv/mcurb_ram.sv =====
// Byte memory with one access port and a registered read.
module mcurb_ram #(
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  mcurb_pkg::ring_req_t     req,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata
);
	import mcurb_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/mcurb_ptr.sv =====
// Pointer file and push/pop decision for every channel's transmit and receive rings.
module mcurb_ptr #(
	parameter int CHANNELS   = mcurb_pkg::DEF_CHANNELS,
	parameter int RING_DEPTH = mcurb_pkg::DEF_RING_DEPTH,
	localparam int MW        = $clog2(CHANNELS * RING_DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  mcurb_pkg::cmd_item_t    cmd,
	output mcurb_pkg::ring_req_t    tx_req,
	output mcurb_pkg::ring_req_t    rx_req,
	output logic [MW-1:0]           addr,
	output mcurb_pkg::ring_status_t status
);
	import mcurb_pkg::*;

	localparam int SPAN = 2 * RING_DEPTH;
	localparam int PW   = $clog2(SPAN);
	localparam int AW   = $clog2(RING_DEPTH);
	localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [PW-1:0] tx_head_q [CHANNELS];
	logic [PW-1:0] tx_tail_q [CHANNELS];
	logic [PW-1:0] rx_head_q [CHANNELS];
	logic [PW-1:0] rx_tail_q [CHANNELS];

	logic [CHW-1:0] ch_idx;
	logic           ch_ok;
	logic [PW-1:0]  tx_h, tx_t, rx_h, rx_t;
	logic [PW-1:0]  tx_h_n, tx_t_n, rx_h_n, rx_t_n;
	logic [MW-1:0]  base;
	logic [AW-1:0]  slot;
	mode_t          mode;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(SPAN - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_fill(input logic [PW-1:0] h,
		input logic [PW-1:0] t);
		return (h >= t) ? h - t : h + (PW'(SPAN) - t);
	endfunction

	function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
		return (p >= PW'(RING_DEPTH)) ? AW'(p - PW'(RING_DEPTH)) : AW'(p);
	endfunction

	assign mode   = mode_t'(cmd.mode);
	assign ch_idx = CHW'(cmd.channel);
	assign ch_ok  = int'(cmd.channel) < CHANNELS;
	assign tx_h   = tx_head_q[ch_idx];
	assign tx_t   = tx_tail_q[ch_idx];
	assign rx_h   = rx_head_q[ch_idx];
	assign rx_t   = rx_tail_q[ch_idx];
	assign base   = MW'(MW'(ch_idx) * MW'(RING_DEPTH));
	assign addr   = base + MW'(slot);

	always_comb begin
		tx_h_n = tx_h;
		tx_t_n = tx_t;
		rx_h_n = rx_h;
		rx_t_n = rx_t;
		slot   = ptr_slot(tx_h);
		tx_req = '0;
		rx_req = '0;
		status = '0;
		status.rd_rx = (mode == MODE_RX_POP);
		if (ch_ok) begin
			unique case (mode)
				MODE_TX_POP: begin
					slot = ptr_slot(tx_t);
					if (tx_h != tx_t) begin
						tx_t_n            = ptr_inc(tx_t);
						tx_req.rd         = accept;
						status.data_valid = 1'b1;
					end
				end
				MODE_RX_PUSH: begin
					slot = ptr_slot(rx_h);
					if (ptr_fill(rx_h, rx_t) == PW'(RING_DEPTH)) begin
						status.overflow = 1'b1;
					end else begin
						rx_h_n    = ptr_inc(rx_h);
						rx_req.wr = accept;
					end
				end
				MODE_RX_POP: begin
					slot = ptr_slot(rx_t);
					if (rx_h != rx_t) begin
						rx_t_n            = ptr_inc(rx_t);
						rx_req.rd         = accept;
						status.data_valid = 1'b1;
					end else begin
						status.rx_empty_pop = 1'b1;
					end
				end
				default: begin
					if (ptr_fill(tx_h, tx_t) == PW'(RING_DEPTH)) begin
						status.overflow = 1'b1;
					end else begin
						tx_h_n    = ptr_inc(tx_h);
						tx_req.wr = accept;
					end
				end
			endcase
			status.rx_fill  = 9'(ptr_fill(rx_h_n, rx_t_n));
			status.tx_empty = (tx_h_n == tx_t_n);
		end else begin
			status.tx_empty = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				tx_head_q[i] <= '0;
				tx_tail_q[i] <= '0;
				rx_head_q[i] <= '0;
				rx_tail_q[i] <= '0;
			end
		end else if (accept && ch_ok) begin
			tx_head_q[ch_idx] <= tx_h_n;
			tx_tail_q[ch_idx] <= tx_t_n;
			rx_head_q[ch_idx] <= rx_h_n;
			rx_tail_q[ch_idx] <= rx_t_n;
		end
	end

endmodule

// ===== sv/multi_channel_uart_ring_buffers.sv =====
// Top level: per-channel transmit and receive byte rings with valid/ready channels.
// Each result is held in the stage-one and output registers before it is offered.
// One item per cycle unless the output stalls, set by each memory's single port.
// Reset clears all ring pointers at once, so every ring starts empty; byte stores
// are not cleared and need no clearing pass.
module multi_channel_uart_ring_buffers #(
	parameter int CHANNELS   = mcurb_pkg::DEF_CHANNELS,
	parameter int RING_DEPTH = mcurb_pkg::DEF_RING_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  mcurb_pkg::cmd_item_t cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output mcurb_pkg::rsp_item_t rsp
);
	import mcurb_pkg::*;

	localparam int DEPTH = CHANNELS * RING_DEPTH;
	localparam int MW    = $clog2(DEPTH);

	logic          accept;
	logic          s1_go;
	ring_req_t     tx_req, rx_req;
	logic [MW-1:0] addr;
	ring_status_t  status;
	logic [7:0]    tx_rdata, rx_rdata;
	logic [7:0]    data_out;

	logic          s1_v_q;
	ring_status_t  status_s1;
	logic          out_v_q;
	rsp_item_t     rsp_q;

	assign s1_go     = !out_v_q || rsp_ready;
	assign cmd_ready = !s1_v_q || s1_go;
	assign accept    = cmd_valid && cmd_ready;

	mcurb_ptr #(
		.CHANNELS  (CHANNELS),
		.RING_DEPTH(RING_DEPTH)
	) u_ptr (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd   (cmd),
		.tx_req(tx_req),
		.rx_req(rx_req),
		.addr  (addr),
		.status(status)
	);

	mcurb_ram #(
		.DEPTH(DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.req  (tx_req),
		.addr (addr),
		.wdata(cmd.data_in),
		.rdata(tx_rdata)
	);

	mcurb_ram #(
		.DEPTH(DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.req  (rx_req),
		.addr (addr),
		.wdata(cmd.data_in),
		.rdata(rx_rdata)
	);

	always_comb begin
		priority if (status_s1.data_valid) begin
			data_out = status_s1.rd_rx ? rx_rdata : tx_rdata;
		end else if (status_s1.rx_empty_pop) begin
			data_out = EMPTY_RX_BYTE;
		end else begin
			data_out = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd_ready) begin
				s1_v_q <= cmd_valid;
			end
			if (s1_go) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
		end
		if (s1_go && s1_v_q) begin
			rsp_q.data_out   <= data_out;
			rsp_q.data_valid <= status_s1.data_valid;
			rsp_q.rx_fill    <= status_s1.rx_fill;
			rsp_q.tx_empty   <= status_s1.tx_empty;
			rsp_q.overflow   <= status_s1.overflow;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = rsp_q;

endmodule

// ===== test/tb_multi_channel_uart_ring_buffers.sv =====
// Testbench: random and directed ring traffic on every channel, checked against a ring predictor.
`timescale 1ns / 100ps

module tb_multi_channel_uart_ring_buffers;
	import mcurb_pkg::*;

	localparam int CH          = DEF_CHANNELS;
	localparam int DEPTH       = DEF_RING_DEPTH;
	localparam int TOTAL_ITEMS = 1650;
	localparam int QUIET_ITEMS = 200;
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_LIMIT  = 1000;
	localparam int MAX_REPORTS = 10;

	class ring_model;
		logic [7:0] tx_bytes [CH][DEPTH];
		logic [7:0] rx_bytes [CH][DEPTH];
		logic [8:0] tx_wr [CH];
		logic [8:0] tx_rd [CH];
		logic [8:0] rx_wr [CH];
		logic [8:0] rx_rd [CH];
		rsp_item_t  pending_rsp [$];
		int         mismatches;

		function new();
			for (int i = 0; i < CH; i++) begin
				tx_wr[i] = '0;
				tx_rd[i] = '0;
				rx_wr[i] = '0;
				rx_rd[i] = '0;
			end
			mismatches = 0;
		endfunction

		function logic [8:0] fill_of(logic [8:0] wr, logic [8:0] rd);
			logic [8:0] f;
			f = wr - rd;
			return f;
		endfunction

		function void note_cmd(cmd_item_t c);
			rsp_item_t r;
			int        ch;
			r  = '0;
			ch = c.channel;
			case (mode_t'(c.mode))
				MODE_TX_PUSH: begin
					if (fill_of(tx_wr[ch], tx_rd[ch]) == 9'(DEPTH)) begin
						r.overflow = 1'b1;
					end else begin
						tx_bytes[ch][tx_wr[ch] % DEPTH] = c.data_in;
						tx_wr[ch] = tx_wr[ch] + 9'd1;
					end
				end
				MODE_TX_POP: begin
					if (tx_wr[ch] != tx_rd[ch]) begin
						r.data_out   = tx_bytes[ch][tx_rd[ch] % DEPTH];
						r.data_valid = 1'b1;
						tx_rd[ch]    = tx_rd[ch] + 9'd1;
					end
				end
				MODE_RX_PUSH: begin
					if (fill_of(rx_wr[ch], rx_rd[ch]) == 9'(DEPTH)) begin
						r.overflow = 1'b1;
					end else begin
						rx_bytes[ch][rx_wr[ch] % DEPTH] = c.data_in;
						rx_wr[ch] = rx_wr[ch] + 9'd1;
					end
				end
				default: begin
					if (rx_wr[ch] != rx_rd[ch]) begin
						r.data_out   = rx_bytes[ch][rx_rd[ch] % DEPTH];
						r.data_valid = 1'b1;
						rx_rd[ch]    = rx_rd[ch] + 9'd1;
					end else begin
						r.data_out = EMPTY_RX_BYTE;
					end
				end
			endcase
			r.rx_fill  = fill_of(rx_wr[ch], rx_rd[ch]);
			r.tx_empty = (tx_wr[ch] == tx_rd[ch]);
			pending_rsp.push_back(r);
		endfunction

		function void check_rsp(rsp_item_t got);
			rsp_item_t want;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: data_out %h valid %b fill %0d tx_empty %b ovf %b",
						got.data_out, got.data_valid, got.rx_fill, got.tx_empty, got.overflow);
				return;
			end
			want = pending_rsp.pop_front();
			if (got.data_out !== want.data_out || got.data_valid !== want.data_valid ||
				got.rx_fill !== want.rx_fill || got.tx_empty !== want.tx_empty ||
				got.overflow !== want.overflow) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch expected: data_out %h valid %b fill %0d tx_empty %b ovf %b",
						want.data_out, want.data_valid, want.rx_fill, want.tx_empty, want.overflow);
					$display("         actual:   data_out %h valid %b fill %0d tx_empty %b ovf %b",
						got.data_out, got.data_valid, got.rx_fill, got.tx_empty, got.overflow);
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_item_t cmd;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	ring_model rings = new();
	int        items_sent = 0;
	int        results_seen = 0;
	int        idle_cycles = 0;
	bit        no_idle = 1'b0;

	multi_channel_uart_ring_buffers dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic send_cmd(input mode_t m, input int ch, input logic [7:0] d);
		cmd_item_t c;
		int        gap;
		c.mode    = m;
		c.channel = 3'(ch);
		c.data_in = d;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		rings.note_cmd(c);
		items_sent++;
		if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS)
			no_idle = 1'b1;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			rings.check_rsp(rsp);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_multi_channel_uart_ring_buffers NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int  gap;
		bit  held;
		held      = 1'b0;
		rsp_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 200) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				gap = $urandom_range(1, 6);
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		int    kind;
		int    len;
		int    ch;
		int    extra;
		bit    tx_filled;
		bit    rx_filled;
		mode_t m;
		tx_filled = 1'b0;
		rx_filled = 1'b0;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// empty pops, byte extremes, then one push on every channel
		send_cmd(MODE_TX_POP, 0, 8'h00);
		send_cmd(MODE_RX_POP, 0, 8'hFF);
		send_cmd(MODE_TX_PUSH, 0, 8'h00);
		send_cmd(MODE_TX_PUSH, 0, 8'hFF);
		send_cmd(MODE_TX_POP, 0, 8'h00);
		send_cmd(MODE_TX_POP, 0, 8'h00);
		send_cmd(MODE_TX_POP, 0, 8'h00);
		send_cmd(MODE_RX_PUSH, 7, 8'hFF);
		send_cmd(MODE_RX_PUSH, 7, 8'h00);
		send_cmd(MODE_RX_POP, 7, 8'h00);
		send_cmd(MODE_RX_POP, 7, 8'h00);
		send_cmd(MODE_RX_POP, 7, 8'h00);
		for (int i = 0; i < CH; i++)
			send_cmd((i % 2) ? MODE_RX_PUSH : MODE_TX_PUSH, i, 8'(8'h11 * i + 8'h5A));

		while (items_sent < TOTAL_ITEMS) begin
			if (!tx_filled && items_sent >= 300) begin
				tx_filled = 1'b1;
				ch    = $urandom_range(0, CH - 1);
				extra = $urandom_range(1, 8);
				repeat (DEPTH + extra) send_cmd(MODE_TX_PUSH, ch, 8'($urandom_range(0, 255)));
				repeat (DEPTH + extra) send_cmd(MODE_TX_POP, ch, 8'($urandom_range(0, 255)));
			end else if (!rx_filled && items_sent >= 900) begin
				rx_filled = 1'b1;
				ch    = $urandom_range(0, CH - 1);
				extra = $urandom_range(1, 8);
				repeat (DEPTH + extra) send_cmd(MODE_RX_PUSH, ch, 8'($urandom_range(0, 255)));
				repeat (DEPTH + extra) send_cmd(MODE_RX_POP, ch, 8'($urandom_range(0, 255)));
			end else begin
				kind = $urandom_range(0, 9);
				ch   = $urandom_range(0, CH - 1);
				if (kind <= 3) begin
					len = $urandom_range(1, 16);
					repeat (len) begin
						m = mode_t'($urandom_range(0, 3));
						if ($urandom_range(0, 1))
							ch = $urandom_range(0, CH - 1);
						send_cmd(m, ch, 8'($urandom_range(0, 255)));
					end
				end else if (kind <= 6) begin
					len = $urandom_range(1, 24);
					m   = $urandom_range(0, 1) ? MODE_TX_PUSH : MODE_RX_PUSH;
					repeat (len) send_cmd(m, ch, 8'($urandom_range(0, 255)));
				end else begin
					len = $urandom_range(1, 24);
					m   = $urandom_range(0, 1) ? MODE_TX_POP : MODE_RX_POP;
					repeat (len) send_cmd(m, ch, 8'($urandom_range(0, 255)));
				end
			end
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (rings.pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (rings.mismatches == 0) begin
			$display("tb_multi_channel_uart_ring_buffers OK");
		end else begin
			$display("tb_multi_channel_uart_ring_buffers NOT OK");
		end
		$finish;
	end

endmodule

// ===== multi_channel_uart_ring_buffers.f =====
sv/mcurb_pkg.sv
sv/mcurb_ram.sv
sv/mcurb_ptr.sv
sv/multi_channel_uart_ring_buffers.sv
test/tb_multi_channel_uart_ring_buffers.sv
